>>> hw/rtl/bmf_pkg.sv
package bmf_pkg;

   localparam int PAGES_PER_BLK_DEF = 32;
   localparam int DATA_BLOCKS_DEF   = 256;

   localparam int SECTOR_W = 13;
   localparam int PAGE_W   = 14;
   localparam int ERASE_W  = 9;
   localparam int OP_W     = 2;
   localparam int STEP_W   = 4;

   typedef logic [OP_W-1:0] flash_op_type;

   localparam flash_op_type FOP_READ    = 2'd0;
   localparam flash_op_type FOP_COPY    = 2'd1;
   localparam flash_op_type FOP_ERASE   = 2'd2;
   localparam flash_op_type FOP_PROGRAM = 2'd3;

   typedef logic [STEP_W-1:0] step_type;

   localparam step_type STEP_IDLE     = 4'd0;
   localparam step_type STEP_DIV      = 4'd1;
   localparam step_type STEP_LOOKUP   = 4'd2;
   localparam step_type STEP_PBN      = 4'd3;
   localparam step_type STEP_LOAD_PW  = 4'd4;
   localparam step_type STEP_BR_READ  = 4'd5;
   localparam step_type STEP_BR_DROP  = 4'd6;
   localparam step_type STEP_BR_ALLOC = 4'd7;
   localparam step_type STEP_BR_CLEAN = 4'd8;
   localparam step_type STEP_COPY     = 4'd9;
   localparam step_type STEP_ERASE    = 4'd10;
   localparam step_type STEP_WIPE     = 4'd11;
   localparam step_type STEP_ALLOC    = 4'd12;
   localparam step_type STEP_PROGRAM  = 4'd13;
   localparam step_type STEP_READ     = 4'd14;

   // datapath action of one control word
   typedef enum logic [3:0] {
      ACT_NOP,
      ACT_DIV,
      ACT_LOOKUP,
      ACT_PBN,
      ACT_LOAD_PW,
      ACT_COPY,
      ACT_ERASE,
      ACT_WIPE,
      ACT_ALLOC,
      ACT_PROGRAM,
      ACT_READ
   } act_type;

   // jump condition of one control word, fall through when false
   typedef enum logic [2:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_NO_START,
      COND_READ,
      COND_DROP,
      COND_UNMAPPED,
      COND_CLEAN,
      COND_COPY_MORE
   } cond_type;

   typedef struct packed {
      act_type  act;
      cond_type cond;
      step_type target;
   } uword_type;

   typedef struct packed {
      logic start;
      logic is_read;
      logic drop;
      logic unmapped;
      logic clean;
      logic copy_more;
   } flags_type;

   function automatic uword_type ucode(step_type step);
      uword_type w;
      unique case (step)
         STEP_IDLE:     w = '{act: ACT_NOP,     cond: COND_NO_START,  target: STEP_IDLE};
         STEP_DIV:      w = '{act: ACT_DIV,     cond: COND_NEVER,     target: STEP_IDLE};
         STEP_LOOKUP:   w = '{act: ACT_LOOKUP,  cond: COND_NEVER,     target: STEP_IDLE};
         STEP_PBN:      w = '{act: ACT_PBN,     cond: COND_NEVER,     target: STEP_IDLE};
         STEP_LOAD_PW:  w = '{act: ACT_LOAD_PW, cond: COND_NEVER,     target: STEP_IDLE};
         STEP_BR_READ:  w = '{act: ACT_NOP,     cond: COND_READ,      target: STEP_READ};
         STEP_BR_DROP:  w = '{act: ACT_NOP,     cond: COND_DROP,      target: STEP_IDLE};
         STEP_BR_ALLOC: w = '{act: ACT_NOP,     cond: COND_UNMAPPED,  target: STEP_ALLOC};
         STEP_BR_CLEAN: w = '{act: ACT_NOP,     cond: COND_CLEAN,     target: STEP_PROGRAM};
         STEP_COPY:     w = '{act: ACT_COPY,    cond: COND_COPY_MORE, target: STEP_COPY};
         STEP_ERASE:    w = '{act: ACT_ERASE,   cond: COND_NEVER,     target: STEP_IDLE};
         STEP_WIPE:     w = '{act: ACT_WIPE,    cond: COND_ALWAYS,    target: STEP_PROGRAM};
         STEP_ALLOC:    w = '{act: ACT_ALLOC,   cond: COND_NEVER,     target: STEP_IDLE};
         STEP_PROGRAM:  w = '{act: ACT_PROGRAM, cond: COND_ALWAYS,    target: STEP_IDLE};
         STEP_READ:     w = '{act: ACT_READ,    cond: COND_ALWAYS,    target: STEP_IDLE};
         default:       w = '{act: ACT_NOP,     cond: COND_ALWAYS,    target: STEP_IDLE};
      endcase
      return w;
   endfunction

endpackage

>>> hw/rtl/bmf_ram.sv
module bmf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> hw/rtl/bmf_useq.sv
module bmf_useq (
   input  logic                clock,
   input  logic                reset,
   input  bmf_pkg::flags_type  flags,
   output bmf_pkg::act_type    act,
   output logic                busy
);

   import bmf_pkg::*;

   step_type  step_ff;
   step_type  step_in;
   uword_type word;
   logic      take_jump;

   assign word = ucode(step_ff);

   always_comb begin
      unique case (word.cond)
         COND_NEVER:     take_jump = 1'b0;
         COND_ALWAYS:    take_jump = 1'b1;
         COND_NO_START:  take_jump = !flags.start;
         COND_READ:      take_jump = flags.is_read;
         COND_DROP:      take_jump = flags.drop;
         COND_UNMAPPED:  take_jump = flags.unmapped;
         COND_CLEAN:     take_jump = flags.clean;
         COND_COPY_MORE: take_jump = flags.copy_more;
         default:        take_jump = 1'b1;
      endcase
      step_in = take_jump ? word.target : step_ff + step_type'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

   assign act  = word.act;
   assign busy = (step_ff != STEP_IDLE);

endmodule

>>> hw/rtl/block_mapping_ftl_unit.sv
// a read gives a single read result; a write to a clean page or an unmapped block gives a single
// program result; an overwrite gives a copy result per surviving page, an erase, then the program;
// a dropped write gives no result.
// one transaction at a time; busy drops in the cycle that shows the last result.
// synchronous reset clears the mapped flags, allocator and spare; pages of blocks never
// allocated read as erased, so there is no clearing pass. results cannot be stalled.
module block_mapping_ftl_unit #(
   parameter int PAGES_PER_BLK = bmf_pkg::PAGES_PER_BLK_DEF,
   parameter int DATA_BLOCKS   = bmf_pkg::DATA_BLOCKS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_type,
   input  logic [bmf_pkg::SECTOR_W-1:0]  req_logical_sector,
   output logic                          rsp_strobe,
   output logic [bmf_pkg::OP_W-1:0]      rsp_flash_op,
   output logic [bmf_pkg::PAGE_W-1:0]    rsp_page_addr,
   output logic [bmf_pkg::PAGE_W-1:0]    rsp_dest_page,
   output logic [bmf_pkg::ERASE_W-1:0]   rsp_erase_block,
   output logic                          rsp_found,
   output logic                          rsp_last
);

   import bmf_pkg::*;

   localparam int OFF_W     = $clog2(PAGES_PER_BLK);
   localparam int PBN_W     = $clog2(DATA_BLOCKS + 1);
   localparam int MAP_AW    = $clog2(DATA_BLOCKS);
   localparam int LBN_RAW_W = $clog2((2**SECTOR_W - 1) / PAGES_PER_BLK + 1);
   localparam int LBN_W     = (LBN_RAW_W > MAP_AW) ? LBN_RAW_W : MAP_AW;
   // sector / pages per block as multiply by reciprocal, exact over all sectors
   localparam int DIV_SHIFT = SECTOR_W + OFF_W;
   localparam int DIV_MUL   = (2**DIV_SHIFT + PAGES_PER_BLK - 1) / PAGES_PER_BLK;
   localparam int MUL_W     = $clog2(DIV_MUL + 1);
   localparam int PROD_W    = SECTOR_W + MUL_W;

   function automatic logic [PAGE_W-1:0] page_of(logic [PBN_W-1:0] pbn,
                                                 logic [OFF_W-1:0] off);
      return PAGE_W'(PAGE_W'(pbn) * PAGE_W'(PAGES_PER_BLK) + PAGE_W'(off));
   endfunction

   act_type   act;
   flags_type flags;

   // transaction registers
   logic                     is_write_ff, is_write_in;
   logic [SECTOR_W-1:0]      sector_ff, sector_in;
   logic [LBN_W-1:0]         lbn_ff, lbn_in;
   logic [OFF_W-1:0]         off_ff, off_in;
   logic                     mapped_ff, mapped_in;
   logic [PBN_W-1:0]         pbn_ff, pbn_in;
   logic [PAGES_PER_BLK-1:0] pw_ff, pw_in;
   logic [PAGES_PER_BLK-1:0] rem_ff, rem_in;

   // persistent control state
   logic [PBN_W-1:0]         next_unused_ff, next_unused_in;
   logic [PBN_W-1:0]         spare_ff, spare_in;
   logic                     top_used_ff, top_used_in;
   logic [DATA_BLOCKS-1:0]   mapped_flags_ff, mapped_flags_in;

   // result registers
   logic                     rsp_strobe_ff, rsp_strobe_in;
   flash_op_type             rsp_op_ff, rsp_op_in;
   logic [PAGE_W-1:0]        rsp_page_ff, rsp_page_in;
   logic [PAGE_W-1:0]        rsp_dest_ff, rsp_dest_in;
   logic [ERASE_W-1:0]       rsp_erase_ff, rsp_erase_in;
   logic                     rsp_found_ff, rsp_found_in;
   logic                     rsp_last_ff, rsp_last_in;

   // memories
   logic                     map_we;
   logic [MAP_AW-1:0]        map_addr;
   logic [PBN_W-1:0]         map_wdata, map_rdata;
   logic                     pw_we;
   logic [PBN_W-1:0]         pw_waddr, pw_raddr;
   logic [PAGES_PER_BLK-1:0] pw_wdata, pw_rdata;

   logic                     in_range;
   logic                     pw_valid;
   logic [PAGES_PER_BLK-1:0] bit_mask;
   logic [PAGES_PER_BLK-1:0] low_bit;
   logic [OFF_W-1:0]         low_idx;
   logic [PROD_W-1:0]        div_prod;

   bmf_useq u_useq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .act   (act),
      .busy  (busy)
   );

   bmf_ram #(.WIDTH(PBN_W), .DEPTH(DATA_BLOCKS)) u_map_ram (
      .clock (clock),
      .we    (map_we),
      .waddr (map_addr),
      .wdata (map_wdata),
      .raddr (map_addr),
      .rdata (map_rdata)
   );

   bmf_ram #(.WIDTH(PAGES_PER_BLK), .DEPTH(DATA_BLOCKS + 1)) u_pw_ram (
      .clock (clock),
      .we    (pw_we),
      .waddr (pw_waddr),
      .wdata (pw_wdata),
      .raddr (pw_raddr),
      .rdata (pw_rdata)
   );

   assign in_range = (32'(lbn_ff) < 32'(DATA_BLOCKS));
   assign map_addr = lbn_ff[MAP_AW-1:0];
   assign pw_raddr = mapped_ff ? map_rdata : next_unused_ff;
   assign bit_mask = PAGES_PER_BLK'(1) << off_ff;
   assign low_bit  = rem_ff & (~rem_ff + PAGES_PER_BLK'(1));
   assign div_prod = PROD_W'(sector_ff) * PROD_W'(DIV_MUL);
   // a block holds data only once allocated, or once the initial spare was taken
   assign pw_valid = (pbn_ff < next_unused_ff)
                     || ((pbn_ff == PBN_W'(DATA_BLOCKS)) && top_used_ff);

   always_comb begin
      low_idx = '0;
      for (int i = 0; i < PAGES_PER_BLK; i++) begin
         if (low_bit[i]) begin
            low_idx = low_idx | OFF_W'(i);
         end
      end
   end

   always_comb begin
      flags.start     = start;
      flags.is_read   = !is_write_ff;
      flags.drop      = !in_range
                        || (!mapped_ff && (next_unused_ff >= PBN_W'(DATA_BLOCKS)));
      flags.unmapped  = !mapped_ff;
      flags.clean     = !pw_ff[off_ff];
      flags.copy_more = |(rem_ff & (rem_ff - PAGES_PER_BLK'(1)));
   end

   always_comb begin
      is_write_in     = is_write_ff;
      sector_in       = sector_ff;
      lbn_in          = lbn_ff;
      off_in          = off_ff;
      mapped_in       = mapped_ff;
      pbn_in          = pbn_ff;
      pw_in           = pw_ff;
      rem_in          = rem_ff;
      next_unused_in  = next_unused_ff;
      spare_in        = spare_ff;
      top_used_in     = top_used_ff;
      mapped_flags_in = mapped_flags_ff;
      rsp_strobe_in   = 1'b0;
      rsp_op_in       = rsp_op_ff;
      rsp_page_in     = rsp_page_ff;
      rsp_dest_in     = rsp_dest_ff;
      rsp_erase_in    = rsp_erase_ff;
      rsp_found_in    = rsp_found_ff;
      rsp_last_in     = rsp_last_ff;
      map_we          = 1'b0;
      map_wdata       = spare_ff;
      pw_we           = 1'b0;
      pw_waddr        = pbn_ff;
      pw_wdata        = '0;

      if (start && !busy) begin
         is_write_in = req_type;
         sector_in   = req_logical_sector;
      end

      case (act)
         ACT_DIV: begin
            lbn_in = LBN_W'(div_prod >> DIV_SHIFT);
         end
         ACT_LOOKUP: begin
            off_in    = OFF_W'(sector_ff
                        - SECTOR_W'(SECTOR_W'(lbn_ff) * SECTOR_W'(PAGES_PER_BLK)));
            mapped_in = in_range && mapped_flags_ff[map_addr];
         end
         ACT_PBN: begin
            pbn_in = pw_raddr;
         end
         ACT_LOAD_PW: begin
            pw_in  = pw_valid ? pw_rdata : '0;
            rem_in = (pw_valid ? pw_rdata : '0) & ~bit_mask;
         end
         ACT_COPY: begin
            if (|rem_ff) begin
               rsp_strobe_in = 1'b1;
               rsp_op_in     = FOP_COPY;
               rsp_page_in   = page_of(pbn_ff, low_idx);
               rsp_dest_in   = page_of(spare_ff, low_idx);
               rsp_erase_in  = '0;
               rsp_found_in  = 1'b0;
               rsp_last_in   = 1'b0;
            end
            rem_in = rem_ff & ~low_bit;
         end
         ACT_ERASE: begin
            // spare takes the surviving pages, old block becomes the spare
            pw_we     = 1'b1;
            pw_waddr  = spare_ff;
            pw_wdata  = pw_ff & ~bit_mask;
            map_we    = 1'b1;
            map_wdata = spare_ff;
            spare_in  = pbn_ff;
            pbn_in    = spare_ff;
            if (spare_ff == PBN_W'(DATA_BLOCKS)) begin
               top_used_in = 1'b1;
            end
            rsp_strobe_in = 1'b1;
            rsp_op_in     = FOP_ERASE;
            rsp_page_in   = '0;
            rsp_dest_in   = '0;
            rsp_erase_in  = ERASE_W'(pbn_ff);
            rsp_found_in  = 1'b0;
            rsp_last_in   = 1'b0;
         end
         ACT_WIPE: begin
            pw_we    = 1'b1;
            pw_waddr = spare_ff;
            pw_wdata = '0;
         end
         ACT_ALLOC: begin
            map_we                    = 1'b1;
            map_wdata                 = next_unused_ff;
            mapped_flags_in[map_addr] = 1'b1;
            next_unused_in            = next_unused_ff + PBN_W'(1);
         end
         ACT_PROGRAM: begin
            pw_we         = 1'b1;
            pw_waddr      = pbn_ff;
            pw_wdata      = pw_ff | bit_mask;
            rsp_strobe_in = 1'b1;
            rsp_op_in     = FOP_PROGRAM;
            rsp_page_in   = page_of(pbn_ff, off_ff);
            rsp_dest_in   = '0;
            rsp_erase_in  = '0;
            rsp_found_in  = 1'b0;
            rsp_last_in   = 1'b1;
         end
         ACT_READ: begin
            rsp_strobe_in = 1'b1;
            rsp_op_in     = FOP_READ;
            rsp_page_in   = mapped_ff ? page_of(pbn_ff, off_ff) : '0;
            rsp_dest_in   = '0;
            rsp_erase_in  = '0;
            rsp_found_in  = mapped_ff && pw_ff[off_ff];
            rsp_last_in   = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_unused_ff  <= '0;
         spare_ff        <= PBN_W'(DATA_BLOCKS);
         top_used_ff     <= 1'b0;
         mapped_flags_ff <= '0;
         rsp_strobe_ff   <= 1'b0;
      end else begin
         next_unused_ff  <= next_unused_in;
         spare_ff        <= spare_in;
         top_used_ff     <= top_used_in;
         mapped_flags_ff <= mapped_flags_in;
         rsp_strobe_ff   <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      is_write_ff  <= is_write_in;
      sector_ff    <= sector_in;
      lbn_ff       <= lbn_in;
      off_ff       <= off_in;
      mapped_ff    <= mapped_in;
      pbn_ff       <= pbn_in;
      pw_ff        <= pw_in;
      rem_ff       <= rem_in;
      rsp_op_ff    <= rsp_op_in;
      rsp_page_ff  <= rsp_page_in;
      rsp_dest_ff  <= rsp_dest_in;
      rsp_erase_ff <= rsp_erase_in;
      rsp_found_ff <= rsp_found_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_flash_op    = rsp_op_ff;
   assign rsp_page_addr   = rsp_page_ff;
   assign rsp_dest_page   = rsp_dest_ff;
   assign rsp_erase_block = rsp_erase_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_last        = rsp_last_ff;

   // the final result of a transaction shows as the sequencer returns to idle
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last |-> !busy)
      else $error("last result while sequencer still busy");

   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last |-> busy)
      else $error("intermediate result after transaction ended");

   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_flash_op == FOP_ERASE) |=> rsp_strobe_ff == 1'b0)
      else $error("erase not followed by a gap cycle");

   assert property (@(posedge clock) disable iff (reset)
      next_unused_ff <= PBN_W'(DATA_BLOCKS))
      else $error("allocator ran past the data blocks");

endmodule
